FILE: rtl/dual_pulse_sound_channel_top_defines.svh
// assertion macros for the dual pulse sound channel
`ifndef DUAL_PULSE_SOUND_CHANNEL_TOP_DEFINES_SVH
`define DUAL_PULSE_SOUND_CHANNEL_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DPSC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dpsc check failed");

// next-cycle implication, disabled in reset
`define DPSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dpsc check failed");

`endif

FILE: rtl/dpsc_pkg.sv
// shared types, constants and tables of the dual pulse sound channel
package dpsc_pkg;

    localparam int CYCLE_RATE_W = 25;
    localparam int SPF_W        = 12;
    localparam int PERIOD_W     = 11;
    localparam int RELOAD_W     = 19;
    localparam int LEN_W        = 23;
    localparam int TMR_W        = 20;
    localparam int PHASE_W      = 29;
    localparam int FREQ_W       = 28;
    localparam int LAST_W       = 13;
    localparam int TOTAL_W      = 19;
    localparam int CNT_W        = 7;
    localparam int SAMPLE_W     = 15;
    localparam int DIVIDEND_W   = 18;
    localparam int QUOT_W       = 12;

    localparam logic [CYCLE_RATE_W-1:0] CYCLE_RATE_RST = 25'd5319480;
    localparam logic [SPF_W-1:0]        SPF_RST        = 12'd367;
    localparam logic [RELOAD_W-1:0]     RELOAD_RST     = 19'd1835;
    localparam logic [3:0]              DUTY_LIMIT_RST = 4'd2;
    localparam logic [PERIOD_W-1:0]     MIN_PERIOD     = 11'd7;
    localparam logic [LEN_W-1:0]        LEN_STEP       = 23'd5;
    localparam logic signed [PHASE_W-1:0] ENV_DEC      = -29'sd20;
    localparam logic [4:0]              OFF_RAW        = 5'd17;
    localparam logic [4:0]              OFF_MASK       = 5'd21;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_RENDER = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CH_PULSE0 = 2'd0,
        CH_PULSE1 = 2'd1,
        CH_RAW    = 2'd2,
        CH_SILENT = 2'd3
    } chan_t;

    typedef enum logic [1:0] {
        CHR_CTRL      = 2'd0,
        CHR_UNUSED    = 2'd1,
        CHR_PERIOD_LO = 2'd2,
        CHR_PERIOD_HI = 2'd3
    } chreg_t;

    typedef enum logic {
        CFG_CYCLE_RATE = 1'b0,
        CFG_SPF        = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_ENV,
        ST_PHASE_SUB,
        ST_PHASE_CHK,
        ST_ACC,
        ST_DIV,
        ST_FIN,
        ST_WB,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic negate;
    } div_ctrl_t;

    function automatic logic [6:0] len_lookup(input logic [4:0] idx);
        logic [6:0] v;
        case (idx)
            5'd0:  v = 7'd5;
            5'd1:  v = 7'd127;
            5'd2:  v = 7'd10;
            5'd3:  v = 7'd1;
            5'd4:  v = 7'd19;
            5'd5:  v = 7'd2;
            5'd6:  v = 7'd40;
            5'd7:  v = 7'd3;
            5'd8:  v = 7'd80;
            5'd9:  v = 7'd4;
            5'd10: v = 7'd30;
            5'd11: v = 7'd5;
            5'd12: v = 7'd7;
            5'd13: v = 7'd6;
            5'd14: v = 7'd13;
            5'd15: v = 7'd7;
            5'd16: v = 7'd6;
            5'd17: v = 7'd8;
            5'd18: v = 7'd12;
            5'd19: v = 7'd9;
            5'd20: v = 7'd24;
            5'd21: v = 7'd10;
            5'd22: v = 7'd48;
            5'd23: v = 7'd11;
            5'd24: v = 7'd96;
            5'd25: v = 7'd12;
            5'd26: v = 7'd36;
            5'd27: v = 7'd13;
            5'd28: v = 7'd8;
            5'd29: v = 7'd14;
            5'd30: v = 7'd16;
            5'd31: v = 7'd15;
            default: v = 7'd0;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] duty_lookup(input logic [1:0] idx);
        logic [3:0] v;
        case (idx)
            2'd0: v = 4'd2;
            2'd1: v = 4'd4;
            2'd2: v = 4'd8;
            2'd3: v = 4'd12;
            default: v = 4'd2;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] env_next(input logic [3:0] lvl, input logic hold);
        logic [3:0] v;
        if (hold) begin
            v = lvl + 4'd1;
        end else if (lvl != 4'd15) begin
            v = lvl + 4'd1;
        end else begin
            v = lvl;
        end
        return v;
    endfunction

    function automatic logic signed [LAST_W-1:0] duty_level(
        input logic [3:0] step,
        input logic [3:0] limit,
        input logic signed [LAST_W-1:0] amp
    );
        return (step < limit) ? amp : -amp;
    endfunction

endpackage

FILE: rtl/dpsc_div.sv
// iterative restoring divider for the substep average
module dpsc_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  dpsc_pkg::div_ctrl_t                    ctrl,
    input  logic [dpsc_pkg::DIVIDEND_W-1:0]        dividend,
    input  logic [dpsc_pkg::CNT_W-1:0]             divisor,
    output logic                                   done,
    output logic signed [dpsc_pkg::LAST_W-1:0]    quotient
);

    localparam logic [4:0] LAST_STEP = 5'(dpsc_pkg::DIVIDEND_W - 1);

    logic                                busy_reg;
    logic                                done_reg;
    logic [4:0]                          step_reg;
    logic                                neg_reg;
    logic [dpsc_pkg::CNT_W-1:0]          rem_reg;
    logic [dpsc_pkg::CNT_W-1:0]          div_reg;
    logic [dpsc_pkg::DIVIDEND_W-1:0]     quo_reg;
    logic [dpsc_pkg::CNT_W:0]            trial;
    logic                                fits;
    logic [dpsc_pkg::CNT_W:0]            diff;
    logic [dpsc_pkg::LAST_W-1:0]         mag;

    assign trial = {rem_reg, quo_reg[dpsc_pkg::DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};
    assign mag   = {1'b0, quo_reg[dpsc_pkg::QUOT_W-1:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                step_reg <= LAST_STEP;
            end else if (busy_reg) begin
                step_reg <= step_reg - 5'd1;
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
            neg_reg <= ctrl.negate;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[dpsc_pkg::CNT_W-1:0] : trial[dpsc_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[dpsc_pkg::DIVIDEND_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag) : $signed(mag);

endmodule

FILE: rtl/dual_pulse_sound_channel_top.sv
// dual pulse sound channel: register file, sequencer and shared adder datapath
//
// Two square pulse channels with length counter and envelope, plus a raw
// 8-bit level channel. One input beat is either a register write or a
// render request for one channel; every input beat yields one output beat.
// s_ready is high only while the sequencer is idle; one beat is in work at a
// time. A write, a silent or raw render, or a render of an inactive pulse
// channel goes from START to DONE. A pulse render passes START, ENV (one
// envelope clock at most with four or more samples per frame), PHASE_SUB,
// then WB for a period below 7, else PHASE_CHK and FIN, or, when several
// duty steps fall in one sample, ACC (one substep per pass, at most 64 at
// the largest cycle rate) and the serial divider; the phase/timer adder is
// shared. The next beat can be accepted in the same cycle that m_valid
// rises, and the result may still wait in the output register then. While
// m_ready is low and the output register is full, a newly finished result
// holds the sequencer until it drains. Reset (aresetn low, synchronous)
// clears the channel state (reload and duty limit take defaults), loads the
// default cycle rate and samples per frame, and empties the output.
// Configuration writes are meant for idle periods.
`include "dual_pulse_sound_channel_top_defines.svh"
module dual_pulse_sound_channel_top (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic                                    cfg_index,
    input  logic [dpsc_pkg::CYCLE_RATE_W-1:0]       cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_op,
    input  logic [4:0]                              s_reg_offset,
    input  logic [7:0]                              s_wr_data,
    input  logic [1:0]                              s_chan_sel,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [dpsc_pkg::SAMPLE_W-1:0]   m_sample
);

    localparam int PW = dpsc_pkg::PHASE_W;
    localparam int TW = dpsc_pkg::TMR_W;

    dpsc_pkg::state_t state_reg, state_next;

    logic [dpsc_pkg::CYCLE_RATE_W-1:0] cycle_rate_reg;
    logic [dpsc_pkg::SPF_W-1:0]        spf_reg;

    logic [dpsc_pkg::PERIOD_W-1:0]     period_reg     [2];
    logic [3:0]                        vol_reg        [2];
    logic                              hold_reg       [2];
    logic                              const_reg      [2];
    logic [dpsc_pkg::RELOAD_W-1:0]     reload_reg     [2];
    logic [3:0]                        limit_reg      [2];
    logic [dpsc_pkg::LEN_W-1:0]        len_reg        [2];
    logic [3:0]                        env_reg        [2];
    logic signed [TW-1:0]              tmr_reg        [2];
    logic                              en_reg         [2];
    logic signed [PW-1:0]              phase_reg      [2];
    logic [3:0]                        duty_reg       [2];
    logic signed [dpsc_pkg::LAST_W-1:0] last_reg      [2];
    logic [1:0]                        mask_reg;
    logic [7:0]                        raw_reg;

    logic                              op_reg;
    logic [4:0]                        off_reg;
    logic [7:0]                        data_reg;
    logic [1:0]                        ch_reg;

    logic [dpsc_pkg::LEN_W-1:0]        w_len_reg;
    logic [3:0]                        w_env_reg;
    logic signed [TW-1:0]              w_tmr_reg;
    logic signed [PW-1:0]              w_phase_reg;
    logic [3:0]                        w_duty_reg;
    logic signed [dpsc_pkg::LAST_W-1:0] w_last_reg;
    logic signed [dpsc_pkg::LAST_W-1:0] w_amp_reg;
    logic signed [dpsc_pkg::SAMPLE_W-1:0] w_res_reg;
    logic signed [dpsc_pkg::TOTAL_W-1:0] total_reg;
    logic [dpsc_pkg::CNT_W-1:0]        cnt_reg;

    logic                              m_valid_reg;
    logic signed [dpsc_pkg::SAMPLE_W-1:0] m_sample_reg;

    logic                              c;
    logic                              wc;
    logic                              active;
    logic                              short_period;
    logic [dpsc_pkg::FREQ_W-1:0]       freq;
    logic                              freq_gt_rate;
    logic [14:0]                       spf5;
    logic [dpsc_pkg::RELOAD_W-1:0]     reload_wr;
    logic [dpsc_pkg::LEN_W-1:0]        len_wr;
    logic [dpsc_pkg::LEN_W-1:0]        len_dec;
    logic signed [PW-1:0]              add_a;
    logic signed [PW-1:0]              add_b;
    logic signed [PW-1:0]              add_sum;
    logic [3:0]                        duty_inc;
    logic signed [dpsc_pkg::LAST_W-1:0] acc_lvl;
    logic signed [dpsc_pkg::LAST_W-1:0] fin_lvl;
    logic [3:0]                        amp_code;
    logic                              out_free;
    logic                              in_fire;
    dpsc_pkg::div_ctrl_t               div_ctrl;
    logic [dpsc_pkg::DIVIDEND_W-1:0]   div_dividend;
    logic                              div_done;
    logic signed [dpsc_pkg::LAST_W-1:0] div_quot;
    logic signed [dpsc_pkg::TOTAL_W-1:0] total_neg;

    assign c        = ch_reg[0];
    assign wc       = off_reg[2];
    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign active       = en_reg[c] && (len_reg[c] != '0);
    assign short_period = period_reg[c] < dpsc_pkg::MIN_PERIOD;
    assign freq         = {({1'b0, period_reg[c]} + 12'd1), 16'b0};
    assign freq_gt_rate = freq > {3'b0, cycle_rate_reg};
    assign spf5         = {3'b0, spf_reg} * 15'd5;
    assign reload_wr    = {{(dpsc_pkg::RELOAD_W-5){1'b0}}, ({1'b0, data_reg[3:0]} + 5'd1)}
                          * {{(dpsc_pkg::RELOAD_W-15){1'b0}}, spf5};
    assign len_wr       = {{(dpsc_pkg::LEN_W-7){1'b0}}, dpsc_pkg::len_lookup(data_reg[7:3])}
                          * {{(dpsc_pkg::LEN_W-15){1'b0}}, spf5};
    assign len_dec      = (len_reg[c] > dpsc_pkg::LEN_STEP) ? len_reg[c] - dpsc_pkg::LEN_STEP
                                                            : '0;
    assign duty_inc     = w_duty_reg + 4'd1;
    assign acc_lvl      = dpsc_pkg::duty_level(duty_inc, limit_reg[c], w_amp_reg);
    assign fin_lvl      = dpsc_pkg::duty_level(w_duty_reg, limit_reg[c], w_amp_reg);
    assign amp_code     = const_reg[c] ? vol_reg[c] : 4'd15 - w_env_reg;
    assign total_neg    = -total_reg;
    assign div_dividend = total_reg[dpsc_pkg::TOTAL_W-1] ? total_neg[dpsc_pkg::DIVIDEND_W-1:0]
                                                         : total_reg[dpsc_pkg::DIVIDEND_W-1:0];

    // shared adder for envelope timer and phase
    always_comb begin
        case (state_reg)
            dpsc_pkg::ST_START: begin
                add_a = {{(PW-TW){tmr_reg[c][TW-1]}}, tmr_reg[c]};
                add_b = dpsc_pkg::ENV_DEC;
            end
            dpsc_pkg::ST_ENV: begin
                add_a = {{(PW-TW){w_tmr_reg[TW-1]}}, w_tmr_reg};
                add_b = {{(PW-dpsc_pkg::RELOAD_W){1'b0}}, reload_reg[c]};
            end
            dpsc_pkg::ST_PHASE_SUB: begin
                add_a = w_phase_reg;
                add_b = -$signed({{(PW-dpsc_pkg::CYCLE_RATE_W){1'b0}}, cycle_rate_reg});
            end
            default: begin
                add_a = w_phase_reg;
                add_b = $signed({{(PW-dpsc_pkg::FREQ_W){1'b0}}, freq});
            end
        endcase
    end
    assign add_sum = add_a + add_b;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dpsc_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = dpsc_pkg::ST_START;
                end
            end
            dpsc_pkg::ST_START: begin
                if (op_reg == dpsc_pkg::OP_RENDER && !ch_reg[1] && active) begin
                    state_next = dpsc_pkg::ST_ENV;
                end else begin
                    state_next = dpsc_pkg::ST_DONE;
                end
            end
            dpsc_pkg::ST_ENV: begin
                if (reload_reg[c] == '0 || !w_tmr_reg[TW-1]) begin
                    state_next = dpsc_pkg::ST_PHASE_SUB;
                end
            end
            dpsc_pkg::ST_PHASE_SUB: begin
                state_next = short_period ? dpsc_pkg::ST_WB : dpsc_pkg::ST_PHASE_CHK;
            end
            dpsc_pkg::ST_PHASE_CHK: begin
                if (!w_phase_reg[PW-1] || freq_gt_rate) begin
                    state_next = dpsc_pkg::ST_FIN;
                end else begin
                    state_next = dpsc_pkg::ST_ACC;
                end
            end
            dpsc_pkg::ST_ACC: begin
                if (!w_phase_reg[PW-1]) begin
                    state_next = dpsc_pkg::ST_DIV;
                end
            end
            dpsc_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = dpsc_pkg::ST_WB;
                end
            end
            dpsc_pkg::ST_FIN: state_next = dpsc_pkg::ST_WB;
            dpsc_pkg::ST_WB:  state_next = dpsc_pkg::ST_DONE;
            dpsc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = dpsc_pkg::ST_IDLE;
                end
            end
            default: state_next = dpsc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready         = 1'b0;
        div_ctrl.start  = 1'b0;
        div_ctrl.negate = total_reg[dpsc_pkg::TOTAL_W-1];
        case (state_reg)
            dpsc_pkg::ST_IDLE: s_ready = 1'b1;
            dpsc_pkg::ST_ACC:  div_ctrl.start = !w_phase_reg[PW-1];
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    dpsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dpsc_pkg::ST_IDLE;
            cycle_rate_reg <= dpsc_pkg::CYCLE_RATE_RST;
            spf_reg        <= dpsc_pkg::SPF_RST;
            mask_reg       <= '0;
            raw_reg        <= '0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                period_reg[i] <= '0;
                vol_reg[i]    <= '0;
                hold_reg[i]   <= 1'b0;
                const_reg[i]  <= 1'b0;
                reload_reg[i] <= dpsc_pkg::RELOAD_RST;
                limit_reg[i]  <= dpsc_pkg::DUTY_LIMIT_RST;
                len_reg[i]    <= '0;
                env_reg[i]    <= '0;
                tmr_reg[i]    <= '0;
                en_reg[i]     <= 1'b0;
                phase_reg[i]  <= '0;
                duty_reg[i]   <= '0;
                last_reg[i]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (dpsc_pkg::cfg_idx_t'(cfg_index))
                    dpsc_pkg::CFG_CYCLE_RATE: cycle_rate_reg <= cfg_wdata;
                    dpsc_pkg::CFG_SPF:        spf_reg <= cfg_wdata[dpsc_pkg::SPF_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == dpsc_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == dpsc_pkg::ST_START && op_reg == dpsc_pkg::OP_WRITE) begin
                if (off_reg[4:3] == 2'b00) begin
                    case (dpsc_pkg::chreg_t'(off_reg[1:0]))
                        dpsc_pkg::CHR_CTRL: begin
                            vol_reg[wc]    <= data_reg[3:0];
                            hold_reg[wc]   <= data_reg[5];
                            const_reg[wc]  <= data_reg[4];
                            reload_reg[wc] <= reload_wr;
                            limit_reg[wc]  <= dpsc_pkg::duty_lookup(data_reg[7:6]);
                        end
                        dpsc_pkg::CHR_PERIOD_LO: begin
                            period_reg[wc][7:0] <= data_reg;
                        end
                        dpsc_pkg::CHR_PERIOD_HI: begin
                            period_reg[wc][10:8] <= data_reg[2:0];
                            len_reg[wc]          <= len_wr;
                            env_reg[wc]          <= '0;
                            if (mask_reg[wc]) begin
                                en_reg[wc] <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (off_reg == dpsc_pkg::OFF_RAW) begin
                    raw_reg <= data_reg;
                end else if (off_reg == dpsc_pkg::OFF_MASK) begin
                    mask_reg <= data_reg[1:0];
                    for (int i = 0; i < 2; i++) begin
                        en_reg[i] <= data_reg[i];
                        if (!data_reg[i]) begin
                            len_reg[i] <= '0;
                        end
                    end
                end
            end
            if (state_reg == dpsc_pkg::ST_WB) begin
                len_reg[c]   <= w_len_reg;
                env_reg[c]   <= w_env_reg;
                tmr_reg[c]   <= w_tmr_reg;
                phase_reg[c] <= w_phase_reg;
                duty_reg[c]  <= w_duty_reg;
                last_reg[c]  <= w_last_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg   <= s_op;
            off_reg  <= s_reg_offset;
            data_reg <= s_wr_data;
            ch_reg   <= s_chan_sel;
        end
        if (state_reg == dpsc_pkg::ST_DONE && out_free) begin
            m_sample_reg <= w_res_reg;
        end
        case (state_reg)
            dpsc_pkg::ST_START: begin
                w_res_reg   <= '0;
                w_len_reg   <= hold_reg[c] ? len_reg[c] : len_dec;
                w_env_reg   <= env_reg[c];
                w_tmr_reg   <= add_sum[TW-1:0];
                w_phase_reg <= phase_reg[c];
                w_duty_reg  <= duty_reg[c];
                w_last_reg  <= last_reg[c];
                if (op_reg == dpsc_pkg::OP_RENDER
                        && dpsc_pkg::chan_t'(ch_reg) == dpsc_pkg::CH_RAW) begin
                    w_res_reg <= {1'b0, raw_reg, 6'b0};
                end
            end
            dpsc_pkg::ST_ENV: begin
                if (reload_reg[c] == '0) begin
                    w_env_reg <= dpsc_pkg::env_next(w_env_reg, hold_reg[c]);
                    w_tmr_reg <= '0;
                end else if (w_tmr_reg[TW-1]) begin
                    w_env_reg <= dpsc_pkg::env_next(w_env_reg, hold_reg[c]);
                    w_tmr_reg <= add_sum[TW-1:0];
                end
            end
            dpsc_pkg::ST_PHASE_SUB: begin
                w_res_reg <= '0;
                if (!short_period) begin
                    w_amp_reg   <= {1'b0, amp_code, 8'b0};
                    w_phase_reg <= add_sum;
                end
            end
            dpsc_pkg::ST_PHASE_CHK: begin
                total_reg <= '0;
                cnt_reg   <= '0;
                if (w_phase_reg[PW-1] && freq_gt_rate) begin
                    w_phase_reg <= add_sum;
                    w_duty_reg  <= duty_inc;
                end
            end
            dpsc_pkg::ST_ACC: begin
                if (w_phase_reg[PW-1]) begin
                    w_phase_reg <= add_sum;
                    w_duty_reg  <= duty_inc;
                    total_reg   <= total_reg
                                   + {{(dpsc_pkg::TOTAL_W-dpsc_pkg::LAST_W){acc_lvl[12]}},
                                      acc_lvl};
                    cnt_reg     <= cnt_reg + 7'd1;
                end
            end
            dpsc_pkg::ST_DIV: begin
                if (div_done) begin
                    w_last_reg <= div_quot;
                    w_res_reg  <= {{2{div_quot[12]}}, div_quot};
                end
            end
            dpsc_pkg::ST_FIN: begin
                w_last_reg <= fin_lvl;
                w_res_reg  <= {{2{fin_lvl[12]}}, fin_lvl};
            end
            default: ;
        endcase
    end

    assign m_valid  = m_valid_reg;
    assign m_sample = m_sample_reg;

    `DPSC_ASSERT_SAME(a_acc_count_bound, aclk, aresetn,
        state_reg == dpsc_pkg::ST_ACC, cnt_reg <= 7'd64)
    `DPSC_ASSERT_SAME(a_div_done_in_div, aclk, aresetn,
        div_done, state_reg == dpsc_pkg::ST_DIV)
    `DPSC_ASSERT_NEXT(a_accept_starts, aclk, aresetn,
        in_fire, state_reg == dpsc_pkg::ST_START)

endmodule
